// ----- design/mms_pkg.sv -----
// ----------------------------------------------------------------------------
// mms_pkg
// shared constants, types and state encoding for the square matrix product
// ----------------------------------------------------------------------------
package mms_pkg;

    localparam int MAX_DIM   = 4;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int CFG_W     = 3;
    localparam int CFG_IDX_W = 1;
    localparam int ACC_W     = 2 * DATA_W + $clog2(MAX_DIM);

    localparam logic [CFG_IDX_W-1:0] REG_DIMENSION   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_VECTOR_MODE = 1'b1;

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_EMIT,
        ST_DRAIN
    } state_t;

    // operand write broadcast to the cells
    typedef struct packed {
        logic              write;
        logic              is_right;
        logic [IDX_W-1:0]  target;
        logic [IDX_W-1:0]  slot;
        logic [DATA_W-1:0] data;
    } load_t;

    // partial sum travelling down the chain
    typedef struct packed {
        logic                    valid;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic                    last;
        logic signed [ACC_W-1:0] psum;
    } token_t;

endpackage

// ----- design/mms_cell.sv -----
// ----------------------------------------------------------------------------
// mms_cell
// one inner-product term: holds column k of the left matrix and row k of the
// right operand, multiplies and adds onto the passing partial sum
// ----------------------------------------------------------------------------
module mms_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [mms_pkg::IDX_W-1:0]  cell_id,
    input  logic [mms_pkg::IDX_W-1:0]  dim_last,
    input  mms_pkg::load_t             load,
    input  mms_pkg::token_t            tok_in,
    output mms_pkg::token_t            tok_out
);

    logic [mms_pkg::DATA_W-1:0] left_reg  [mms_pkg::MAX_DIM];
    logic [mms_pkg::DATA_W-1:0] right_reg [mms_pkg::MAX_DIM];

    mms_pkg::token_t                      tok_mid_reg;
    mms_pkg::token_t                      tok_out_reg;
    logic signed [2*mms_pkg::DATA_W-1:0]  prod_reg;
    logic signed [2*mms_pkg::DATA_W-1:0]  prod_next;
    mms_pkg::token_t                      tok_out_next;
    logic                                 active;

    assign active = (cell_id <= dim_last);

    always_ff @(posedge clk)
    begin
        if (load.write && load.target == cell_id)
        begin
            if (load.is_right)
            begin
                right_reg[load.slot] <= load.data;
            end
            else
            begin
                left_reg[load.slot] <= load.data;
            end
        end
    end

    always_comb
    begin
        if (active)
        begin
            prod_next = $signed(left_reg[tok_in.row]) * $signed(right_reg[tok_in.col]);
        end
        else
        begin
            prod_next = '0;
        end
    end

    always_comb
    begin
        tok_out_next      = tok_mid_reg;
        tok_out_next.psum = tok_mid_reg.psum + mms_pkg::ACC_W'(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_mid_reg <= '0;
            tok_out_reg <= '0;
        end
        else
        begin
            tok_mid_reg <= tok_in;
            tok_out_reg <= tok_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign tok_out = tok_out_reg;

endmodule

// ----- design/matrix_multiply_square.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply_square
// throughput: one operand element per cycle while loading, then one product
// element per cycle; a run has d*d+d*n operand elements
// reset: dimension 4, matrix mode, load run empty; results cannot be stalled
// ----------------------------------------------------------------------------
module matrix_multiply_square (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [mms_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mms_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [mms_pkg::DATA_W-1:0]  element_value,
    output logic                               valid,
    output logic signed [mms_pkg::DATA_W-1:0]  product_value,
    output logic [mms_pkg::IDX_W-1:0]          row_index,
    output logic [mms_pkg::IDX_W-1:0]          column_index,
    output logic                               last_of_run
);

    mms_pkg::state_t state_reg, state_next;

    logic [mms_pkg::IDX_W-1:0] dim_last_reg, dim_last_next;
    logic                      vector_mode_reg, vector_mode_next;
    logic [mms_pkg::IDX_W-1:0] col_last;

    logic                      phase_right_reg, phase_right_next;
    logic [mms_pkg::IDX_W-1:0] load_row_reg, load_row_next;
    logic [mms_pkg::IDX_W-1:0] load_col_reg, load_col_next;
    logic [mms_pkg::IDX_W-1:0] emit_row_reg, emit_row_next;
    logic [mms_pkg::IDX_W-1:0] emit_col_reg, emit_col_next;

    logic accept;
    logic load_done;
    logic emit_last;
    logic issue;

    mms_pkg::load_t  load;
    mms_pkg::token_t tok [mms_pkg::MAX_DIM+1];
    mms_pkg::token_t tok_end;

    logic signed [mms_pkg::ACC_W-1:0]  shifted;
    logic                              fits;
    logic [mms_pkg::DATA_W-1:0]        sat_value;

    logic                              valid_reg;
    logic [mms_pkg::DATA_W-1:0]        product_value_reg;
    logic [mms_pkg::IDX_W-1:0]         row_index_reg;
    logic [mms_pkg::IDX_W-1:0]         column_index_reg;
    logic                              last_of_run_reg;

    assign col_last  = vector_mode_reg ? '0 : dim_last_reg;
    assign accept    = start && !busy;
    assign load_done = phase_right_reg && load_row_reg == dim_last_reg
                       && load_col_reg == col_last;
    assign emit_last = emit_row_reg == dim_last_reg && emit_col_reg == col_last;
    assign tok_end   = tok[mms_pkg::MAX_DIM];

    // configuration
    always_comb
    begin
        dim_last_next    = dim_last_reg;
        vector_mode_next = vector_mode_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                mms_pkg::REG_DIMENSION:
                begin
                    if (cfg_data < mms_pkg::CFG_W'(2))
                    begin
                        dim_last_next = mms_pkg::IDX_W'(1);
                    end
                    else if (cfg_data > mms_pkg::CFG_W'(mms_pkg::MAX_DIM))
                    begin
                        dim_last_next = mms_pkg::IDX_W'(mms_pkg::MAX_DIM - 1);
                    end
                    else
                    begin
                        dim_last_next = mms_pkg::IDX_W'(cfg_data - mms_pkg::CFG_W'(1));
                    end
                end
                mms_pkg::REG_VECTOR_MODE:
                begin
                    vector_mode_next = cfg_data[0];
                end
                default:
                begin
                    dim_last_next = dim_last_reg;
                end
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mms_pkg::ST_LOAD:
            begin
                if (accept && load_done)
                begin
                    state_next = mms_pkg::ST_EMIT;
                end
            end
            mms_pkg::ST_EMIT:
            begin
                if (emit_last)
                begin
                    state_next = mms_pkg::ST_DRAIN;
                end
            end
            mms_pkg::ST_DRAIN:
            begin
                if (tok_end.valid && tok_end.last)
                begin
                    state_next = mms_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = mms_pkg::ST_LOAD;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        busy  = 1'b1;
        issue = 1'b0;
        unique case (state_reg)
            mms_pkg::ST_LOAD:
            begin
                busy = 1'b0;
            end
            mms_pkg::ST_EMIT:
            begin
                issue = 1'b1;
            end
            mms_pkg::ST_DRAIN:
            begin
                busy = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // load and emit counters
    always_comb
    begin
        phase_right_next = phase_right_reg;
        load_row_next    = load_row_reg;
        load_col_next    = load_col_reg;
        emit_row_next    = emit_row_reg;
        emit_col_next    = emit_col_reg;
        if (cfg_write || (accept && load_done))
        begin
            phase_right_next = 1'b0;
            load_row_next    = '0;
            load_col_next    = '0;
        end
        else if (accept)
        begin
            if (load_col_reg == (phase_right_reg ? col_last : dim_last_reg))
            begin
                load_col_next = '0;
                if (load_row_reg == dim_last_reg)
                begin
                    load_row_next    = '0;
                    phase_right_next = 1'b1;
                end
                else
                begin
                    load_row_next = load_row_reg + 1'b1;
                end
            end
            else
            begin
                load_col_next = load_col_reg + 1'b1;
            end
        end
        if (issue)
        begin
            if (emit_col_reg == col_last)
            begin
                emit_col_next = '0;
                emit_row_next = emit_last ? '0 : emit_row_reg + 1'b1;
            end
            else
            begin
                emit_col_next = emit_col_reg + 1'b1;
            end
        end
    end

    // operand write to the cells
    always_comb
    begin
        load.write    = accept;
        load.is_right = phase_right_reg;
        load.target   = phase_right_reg ? load_row_reg : load_col_reg;
        load.slot     = phase_right_reg ? load_col_reg : load_row_reg;
        load.data     = element_value;
    end

    always_comb
    begin
        tok[0].valid = issue;
        tok[0].row   = emit_row_reg;
        tok[0].col   = emit_col_reg;
        tok[0].last  = emit_last;
        tok[0].psum  = '0;
    end

    for (genvar g = 0; g < mms_pkg::MAX_DIM; g++)
    begin : g_cell
        mms_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_id  (mms_pkg::IDX_W'(g)),
            .dim_last (dim_last_reg),
            .load     (load),
            .tok_in   (tok[g]),
            .tok_out  (tok[g+1])
        );
    end

    // scale back and saturate
    always_comb
    begin
        shifted = $signed(tok_end.psum) >>> mms_pkg::FRAC_BITS;
        fits    = (&shifted[mms_pkg::ACC_W-1:mms_pkg::DATA_W-1])
                  || !(|shifted[mms_pkg::ACC_W-1:mms_pkg::DATA_W-1]);
        if (fits)
        begin
            sat_value = shifted[mms_pkg::DATA_W-1:0];
        end
        else if (shifted[mms_pkg::ACC_W-1])
        begin
            sat_value = mms_pkg::SAT_MIN;
        end
        else
        begin
            sat_value = mms_pkg::SAT_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mms_pkg::ST_LOAD;
            dim_last_reg    <= mms_pkg::IDX_W'(mms_pkg::MAX_DIM - 1);
            vector_mode_reg <= 1'b0;
            phase_right_reg <= 1'b0;
            load_row_reg    <= '0;
            load_col_reg    <= '0;
            emit_row_reg    <= '0;
            emit_col_reg    <= '0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            dim_last_reg    <= dim_last_next;
            vector_mode_reg <= vector_mode_next;
            phase_right_reg <= phase_right_next;
            load_row_reg    <= load_row_next;
            load_col_reg    <= load_col_next;
            emit_row_reg    <= emit_row_next;
            emit_col_reg    <= emit_col_next;
            valid_reg       <= tok_end.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        product_value_reg <= sat_value;
        row_index_reg     <= tok_end.row;
        column_index_reg  <= tok_end.col;
        last_of_run_reg   <= tok_end.last;
    end

    assign valid         = valid_reg;
    assign product_value = product_value_reg;
    assign row_index     = row_index_reg;
    assign column_index  = column_index_reg;
    assign last_of_run   = last_of_run_reg;

endmodule
